[src/sfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stream find-and-replace block
// Holds the transaction payload structs, the configuration record and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Width of the configuration write index and data.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  // Input transaction: one text byte and the end-of-text flag.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } sfr_in_t;

  // Result transaction.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } sfr_out_t;

  // Configuration registers as seen by the matching logic.
  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic [63:0] replacement_bytes;
    logic [3:0]  replacement_length;
  } sfr_cfg_t;

endpackage

[src/stream_find_and_replace.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_and_replace: streaming byte find-and-replace
// Replaces non-overlapping occurrences of a configured pattern in a byte
// stream with a configured replacement text, from left to right.
// ----------------------------------------------------------------------------
// Usage:
//   Text enters on the in_ channel, one byte per transaction, with final_byte
//   set on the last byte. Results leave on the out_ channel, one byte per
//   transaction; out_last marks the final result of a text, and a text end
//   that releases no byte gives a single result with out_valid clear.
//   The pattern and replacement are written through the cfg_ port while the
//   block is idle.
//   An input byte is compared with the pattern in the cycle it is accepted,
//   and its first result is offered in the next cycle. A byte that causes k
//   results holds them all in the output register; in_stall is held
//   until the last of them is being taken, so plain pass-through runs at one
//   byte per cycle and replacement or flush bursts run at one result per
//   cycle. A byte that causes no result leaves in_stall low.
//   When the receiver stalls, the current result holds and the input stays
//   stalled for as long as any result of the burst is still waiting.
//   Reset empties the window and the output register and clears all
//   configuration registers to zero, which is pass-through.
// ----------------------------------------------------------------------------
module stream_find_and_replace #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  sfr_pkg::sfr_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output sfr_pkg::sfr_out_t                     out_data
);
  import sfr_pkg::*;

  localparam int BUF = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CW  = $clog2(BUF + 1);

  sfr_cfg_t                cfg_r;
  sfr_out_t [BUF-1:0]      res_list;
  logic     [CW-1:0]       res_cnt;
  sfr_out_t [BUF-1:0]      buf_r;
  logic     [CW-1:0]       rem_r;
  logic                    in_take;
  logic                    out_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PATTERN_BYTES:      cfg_r.pattern_bytes      <= cfg_wdata;
        CFG_PATTERN_LENGTH:     cfg_r.pattern_length     <= cfg_wdata[3:0];
        CFG_REPLACEMENT_BYTES:  cfg_r.replacement_bytes  <= cfg_wdata;
        CFG_REPLACEMENT_LENGTH: cfg_r.replacement_length <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Handshakes: a new byte is taken once the burst in hand is finishing.
  assign out_valid = (rem_r != '0);
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = !((rem_r == '0) || ((rem_r == CW'(1)) && !out_stall));
  assign in_take   = in_valid && !in_stall;

  sfr_window #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_take),
    .item     (in_data),
    .cfg      (cfg_r),
    .res_list (res_list),
    .res_cnt  (res_cnt)
  );

  // Output register: the burst of results, shifted out one per transaction.
  always_ff @(posedge clk) begin
    if (in_take) begin
      buf_r <= res_list;
    end else if (out_take) begin
      buf_r <= buf_r >> $bits(sfr_out_t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (in_take) begin
      rem_r <= res_cnt;
    end else if (out_take) begin
      rem_r <= rem_r - CW'(1);
    end
  end

  assign out_data = buf_r[0];

endmodule

[src/sfr_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_window: match window and per-byte result builder
// Holds the window of recent text bytes, compares it with the pattern when
// it is full and builds the list of result transactions that one input byte
// causes, together with the updated window.
// ----------------------------------------------------------------------------
module sfr_window #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    accept,
  input  sfr_pkg::sfr_in_t                        item,
  input  sfr_pkg::sfr_cfg_t                       cfg,
  output sfr_pkg::sfr_out_t [((MAX_PATTERN > MAX_REPLACEMENT) ?
                              MAX_PATTERN : MAX_REPLACEMENT)-1:0] res_list,
  output logic [$clog2(((MAX_PATTERN > MAX_REPLACEMENT) ?
                        MAX_PATTERN : MAX_REPLACEMENT) + 1)-1:0] res_cnt
);
  import sfr_pkg::*;

  localparam int BUF = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CW  = $clog2(BUF + 1);
  localparam int FW  = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0][7:0] win_r;
  logic [MAX_PATTERN-1:0][7:0] win_nxt;
  logic [FW-1:0]               fill_r;
  logic [FW-1:0]               fill_nxt;

  logic [BUF-1:0][7:0] pushed;
  logic [BUF-1:0][7:0] shifted;
  logic [FW-1:0]       plen;
  logic [CW-1:0]       rlen;
  logic [FW-1:0]       n;
  logic [FW-1:0]       cnt;
  logic                match;
  logic [CW-1:0]       cnt_out;

  // Clamp the configured lengths to what the hardware holds.
  always_comb begin
    if (cfg.pattern_length > 4'(MAX_PATTERN)) begin
      plen = FW'(MAX_PATTERN);
    end else begin
      plen = FW'(cfg.pattern_length);
    end
    if (cfg.replacement_length > 4'(MAX_REPLACEMENT)) begin
      rlen = CW'(MAX_REPLACEMENT);
    end else begin
      rlen = CW'(cfg.replacement_length);
    end
  end

  // Window with the new byte appended; entries past the fill read as zero.
  always_comb begin
    for (int i = 0; i < BUF; i++) begin
      if (i < MAX_PATTERN && FW'(i) < fill_r) begin
        pushed[i] = win_r[i];
      end else if (i < MAX_PATTERN && FW'(i) == fill_r) begin
        pushed[i] = item.text_byte;
      end else begin
        pushed[i] = 8'h00;
      end
    end
    n = fill_r + FW'(1);
  end

  // Parallel compare of the full window with the pattern.
  always_comb begin
    match = (plen != '0) && (n == plen);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (FW'(i) < plen && pushed[i] != cfg.pattern_bytes[8*i +: 8]) begin
        match = 1'b0;
      end
    end
  end

  // Number of window bytes released by this byte.
  always_comb begin
    if (item.final_byte && !match) begin
      cnt = n;
    end else if (plen == '0) begin
      cnt = n;
    end else if (n > plen) begin
      cnt = n - plen + FW'(1);
    end else if (n == plen && !match) begin
      cnt = FW'(1);
    end else begin
      cnt = '0;
    end
  end

  // Result list: replacement text on a match, else the oldest window bytes.
  always_comb begin
    if (match) begin
      cnt_out = rlen;
    end else begin
      cnt_out = CW'(cnt);
    end
    for (int i = 0; i < BUF; i++) begin
      if (match) begin
        res_list[i].out_byte = cfg.replacement_bytes[8*i +: 8];
      end else begin
        res_list[i].out_byte = pushed[i];
      end
      res_list[i].out_valid = 1'b1;
      res_list[i].out_last  = item.final_byte && (CW'(i) == cnt_out - CW'(1));
    end
    res_cnt = cnt_out;
    // An end of text that releases nothing still gives one marker result.
    if (item.final_byte && cnt_out == '0) begin
      res_list[0].out_byte  = 8'h00;
      res_list[0].out_valid = 1'b0;
      res_list[0].out_last  = 1'b1;
      res_cnt               = CW'(1);
    end
  end

  // Remaining window after the released bytes are shifted out.
  always_comb begin
    shifted = pushed >> {cnt, 3'b000};
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_nxt[i] = shifted[i];
    end
    if (item.final_byte || match) begin
      fill_nxt = '0;
    end else begin
      fill_nxt = n - cnt;
    end
  end

  // Window contents need no reset: only entries below the fill are read.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

endmodule
